FILE: rtl/etfs_pkg.sv
//==============================================================================
// etfs_pkg
// Shared types, constants and the log2 fraction table for the fractal block.
//==============================================================================
`default_nettype none

package etfs_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int FRAC_BITS      = 28;
    localparam int ITER_WIDTH     = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int ZW             = 64;
    localparam int SV_WIDTH       = 17;
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = 32;
    localparam int POS_WIDTH      = 6;
    localparam int SMOOTH_WIDTH   = ITER_WIDTH + 17;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CRE   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_CIM   = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_LIMIT = 2'd3;

    localparam logic [ITER_WIDTH-1:0] LIMIT_RESET = ITER_WIDTH'(256);
    localparam logic [SV_WIDTH-1:0]   Q16_ONE     = SV_WIDTH'(65536);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } t_in_item;

    typedef struct packed {
        logic [SV_WIDTH-1:0]   smooth_value;
        logic [ITER_WIDTH-1:0] iteration_count;
        logic                  escaped;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_CHECK, ST_UPDATE,
        ST_LOG1, ST_LOG2, ST_SMOOTH, ST_DIV, ST_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;
        logic mul_start;
        logic [1:0] mul_sel;
        logic update;
        logic log1;
        logic log2;
        logic smooth;
        logic div_start;
        logic div_step;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic mul_done;
        logic escape;
        logic at_limit;
        logic div_done;
    } t_status;

    localparam logic [1:0] MUL_XX = 2'd0;
    localparam logic [1:0] MUL_YY = 2'd1;
    localparam logic [1:0] MUL_XY = 2'd2;

    // log2(1 + i/2^LOG_TABLE_BITS) in Q16, truncated, by bitwise squaring.
    function automatic logic [15:0] log_rom(input logic [LOG_TABLE_BITS-1:0] i);
        logic [63:0] x;
        logic [15:0] r;
        x = (64'd1 << 30) + (64'(i) << (30 - LOG_TABLE_BITS));
        r = '0;
        for (int k = 0; k < 16; k++) begin
            x = (x * x) >> 30;
            r = {r[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                x = x >> 1;
                r[0] = 1'b1;
            end
        end
        return r;
    endfunction

    typedef logic [15:0] t_log_table [2**LOG_TABLE_BITS];

    function automatic t_log_table build_log_table();
        t_log_table tbl;
        for (int i = 0; i < 2**LOG_TABLE_BITS; i++) begin
            tbl[i] = log_rom(LOG_TABLE_BITS'(i));
        end
        return tbl;
    endfunction

    // The fraction table is fixed at elaboration.
    localparam t_log_table LOG_TABLE = build_log_table();

endpackage

`default_nettype wire

FILE: rtl/etfs_ctrl.sv
//==============================================================================
// etfs_ctrl
// Sequencer: start, the iteration loop, the two logarithms and the divide.
//==============================================================================
`default_nettype none

module etfs_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  etfs_pkg::t_status     i_status,
    output etfs_pkg::t_cmd        o_cmd,
    output logic                  o_busy,
    output logic                  o_done
);
    import etfs_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_MUL_A;
                end
            end
            ST_MUL_A: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sel   = MUL_XX;
                n_state         = ST_MUL_B;
            end
            ST_MUL_B: begin
                o_cmd.mul_sel = MUL_XX;
                if (i_status.mul_done) begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_YY;
                    n_state         = ST_MUL_C;
                end
            end
            ST_MUL_C: begin
                o_cmd.mul_sel = MUL_YY;
                if (i_status.mul_done) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_status.escape) begin
                    n_state = ST_LOG1;
                end else if (i_status.at_limit) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_sel   = MUL_XY;
                    n_state         = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.mul_sel = MUL_XY;
                if (i_status.mul_done) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_MUL_A;
                end
            end
            ST_LOG1: begin
                o_cmd.log1 = 1'b1;
                n_state    = ST_LOG2;
            end
            ST_LOG2: begin
                o_cmd.log2 = 1'b1;
                n_state    = ST_SMOOTH;
            end
            ST_SMOOTH: begin
                o_cmd.smooth    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_busy) else $error("done not followed by idle");
    a_load_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> !o_busy) else $error("load while busy");
    a_update_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.update |-> i_status.mul_done) else $error("update without product");
`endif

endmodule

`default_nettype wire

FILE: rtl/etfs_dp.sv
//==============================================================================
// etfs_dp
// Datapath: z registers, a sequential multiplier, the log2 units and a
// restoring divider.
//==============================================================================
`default_nettype none

module etfs_dp (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  etfs_pkg::t_cmd             i_cmd,
    input  etfs_pkg::t_in_item         i_item,
    input  wire                        i_mode,
    input  wire signed [etfs_pkg::COORD_WIDTH-1:0] i_c_re,
    input  wire signed [etfs_pkg::COORD_WIDTH-1:0] i_c_im,
    input  wire [etfs_pkg::ITER_WIDTH-1:0] i_limit,
    output etfs_pkg::t_status          o_status,
    output etfs_pkg::t_out_item        o_result
);
    import etfs_pkg::*;

    localparam logic signed [ZW-1:0] SMAX = {1'b0, {(ZW-1){1'b1}}};
    localparam logic signed [ZW-1:0] SMIN = {1'b1, {(ZW-1){1'b0}}};
    localparam logic signed [ZW-1:0] FOUR = ZW'(1) <<< (FRAC_BITS + 2);

    logic signed [ZW-1:0] r_zx, r_zy, r_cx, r_cy, r_xx, r_yy;
    logic [ITER_WIDTH-1:0] r_iter, r_limit;

    function automatic logic signed [ZW-1:0] sat_add(input logic signed [ZW-1:0] a,
                                                    input logic signed [ZW-1:0] b);
        logic signed [ZW:0] s;
        s = {a[ZW-1], a} + {b[ZW-1], b};
        if (s[ZW] != s[ZW-1]) begin
            return s[ZW] ? SMIN : SMAX;
        end
        return s[ZW-1:0];
    endfunction

    function automatic logic signed [ZW-1:0] sat_neg(input logic signed [ZW-1:0] a);
        if (a == SMIN) begin
            return SMAX;
        end
        return -a;
    endfunction

    // Multiplier: 64x64 magnitude product as four products of 16x64, one a cycle.
    logic [ZW-1:0]   r_ma, r_mb;
    logic [2*ZW-1:0] r_acc;
    logic            r_mneg, r_mbusy;
    logic [1:0]      r_mcnt;
    logic [1:0]      r_msel;
    logic            r_mdone;
    logic signed [ZW-1:0] w_opa, w_opb;
    logic [ZW-1:0]   w_ua, w_ub;

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_XX: begin w_opa = r_zx; w_opb = r_zx; end
            MUL_YY: begin w_opa = r_zy; w_opb = r_zy; end
            default: begin w_opa = r_zx; w_opb = r_zy; end
        endcase
        w_ua = w_opa[ZW-1] ? (ZW'(0) - w_opa) : w_opa;
        w_ub = w_opb[ZW-1] ? (ZW'(0) - w_opb) : w_opb;
    end

    logic [ZW+15:0] w_pp;
    assign w_pp = ZW'(r_ma[15:0]) * r_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= '0;
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt + 2'd1;
                if (r_mcnt == 2'd3) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_ma   <= w_ua;
            r_mb   <= w_ub;
            r_mneg <= w_opa[ZW-1] ^ w_opb[ZW-1];
            r_msel <= i_cmd.mul_sel;
            r_acc  <= '0;
        end else if (r_mbusy) begin
            r_acc <= r_acc + ((2*ZW)'(w_pp) << (16 * r_mcnt));
            r_ma  <= r_ma >> 16;
        end
    end

    // Floor shift and saturation of the finished product.
    logic signed [ZW-1:0] w_prod;
    logic [2*ZW-1:0] w_q;
    logic            w_rem;
    always_comb begin
        w_q   = r_acc >> FRAC_BITS;
        w_rem = |r_acc[FRAC_BITS-1:0];
        if (!r_mneg) begin
            w_prod = (|w_q[2*ZW-1:ZW-1]) ? SMAX : w_q[ZW-1:0];
        end else begin
            w_q = w_q + (2*ZW)'(w_rem);
            if ((|w_q[2*ZW-1:ZW]) || (w_q[ZW-1] && |w_q[ZW-2:0])) begin
                w_prod = SMIN;
            end else begin
                w_prod = ZW'(0) - w_q[ZW-1:0];
            end
        end
    end

    logic signed [ZW-1:0] w_mag;
    assign w_mag = sat_add(r_xx, r_yy);

    // log2 in Q16 of a positive value, through a leading-one detector.
    function automatic logic signed [ZW-1:0] log2_q16(input logic [ZW-1:0] m,
                                                     input int fbits);
        int p;
        logic [LOG_TABLE_BITS-1:0] idx;
        logic [ZW-1:0] sh;
        p = 0;
        for (int k = 0; k < ZW; k++) begin
            if (m[k]) p = k;
        end
        if (m == '0) return '0;
        if (p >= LOG_TABLE_BITS) begin
            sh = m >> (p - LOG_TABLE_BITS);
        end else begin
            sh = m << (LOG_TABLE_BITS - p);
        end
        idx = sh[LOG_TABLE_BITS-1:0];
        return (ZW'(p - fbits) <<< 16) + ZW'(LOG_TABLE[idx]);
    endfunction

    logic signed [ZW-1:0] r_l1, r_l2;

    // Restoring divider, one quotient bit a cycle.
    logic [SMOOTH_WIDTH-1:0] r_num, r_quo;
    logic [ITER_WIDTH:0]     r_rem;
    logic [POS_WIDTH-1:0]    r_dcnt;
    logic [ITER_WIDTH:0]     w_trial;
    logic signed [ZW-1:0]    w_smooth;
    logic                    r_esc;

    assign w_smooth = (ZW'(r_iter) <<< 16) - r_l2;
    assign w_trial  = {r_rem[ITER_WIDTH-1:0], r_num[SMOOTH_WIDTH-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_limit <= (i_limit == '0) ? ITER_WIDTH'(1) : i_limit;
            r_iter  <= '0;
            r_esc   <= 1'b0;
            if (i_mode) begin
                r_zx <= ZW'(i_item.point_x);
                r_zy <= ZW'(i_item.point_y);
                r_cx <= ZW'(i_c_re);
                r_cy <= ZW'(i_c_im);
            end else begin
                r_zx <= '0;
                r_zy <= '0;
                r_cx <= ZW'(i_item.point_x);
                r_cy <= ZW'(i_item.point_y);
            end
        end
        // The cross product is consumed directly by the update.
        if (r_mdone) begin
            case (r_msel)
                MUL_XX: r_xx <= w_prod;
                MUL_YY: r_yy <= w_prod;
                default: ;
            endcase
        end
        if (i_cmd.update) begin
            r_zx   <= sat_add(sat_add(r_xx, sat_neg(r_yy)), r_cx);
            r_zy   <= sat_add(sat_add(w_prod, w_prod), r_cy);
            r_iter <= r_iter + ITER_WIDTH'(1);
        end
        if (i_cmd.log1) begin
            r_l1  <= log2_q16(w_mag, FRAC_BITS);
            r_esc <= 1'b1;
        end
        if (i_cmd.log2) begin
            r_l2 <= log2_q16(ZW'(r_l1 >>> 1), 16);
        end
        if (i_cmd.div_start) begin
            r_num  <= w_smooth[ZW-1] ? '0 : w_smooth[SMOOTH_WIDTH-1:0];
            r_rem  <= '0;
            r_quo  <= '0;
            r_dcnt <= '0;
        end else if (i_cmd.div_step) begin
            r_num  <= r_num << 1;
            r_dcnt <= r_dcnt + POS_WIDTH'(1);
            if (w_trial >= {1'b0, r_limit}) begin
                r_rem <= w_trial - {1'b0, r_limit};
                r_quo <= {r_quo[SMOOTH_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[SMOOTH_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign o_status.mul_done = r_mdone;
    assign o_status.escape   = (w_mag >= FOUR);
    assign o_status.at_limit = (r_iter >= r_limit);
    assign o_status.div_done = (r_dcnt == POS_WIDTH'(SMOOTH_WIDTH - 1));

    always_comb begin
        o_result.iteration_count = r_iter;
        o_result.escaped         = r_esc;
        if (!r_esc || (|r_quo[SMOOTH_WIDTH-1:16] && r_quo > SMOOTH_WIDTH'(Q16_ONE))) begin
            o_result.smooth_value = Q16_ONE;
        end else begin
            o_result.smooth_value = r_quo[SV_WIDTH-1:0];
        end
    end

`ifndef SYNTHESIS
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.update |-> r_iter < r_limit) else $error("iteration past limit");
    a_mul_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mdone |=> !r_mdone) else $error("product strobe held");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !r_mbusy) else $error("divide during multiply");
`endif

endmodule

`default_nettype wire

FILE: rtl/escape_time_fractal_smooth.sv
// Each iteration runs the four-step 16x64 multiplier three times; an escape
// adds the two logarithms, the smooth setup and the restoring divider. One point
// at a time: busy stays high until the result cycle, and the one-cycle strobe
// cannot be stalled.
// Synchronous active-low reset returns mode 0, Julia constant 0, limit 256.
//==============================================================================
// escape_time_fractal_smooth
// Mandelbrot/Julia escape-time evaluator with a normalized smooth value.
//==============================================================================
`default_nettype none

module escape_time_fractal_smooth (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  etfs_pkg::t_in_item     i_item,
    output logic                   o_valid,
    output etfs_pkg::t_out_item    o_result,
    input  wire                    i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire [etfs_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire [etfs_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data
);
    import etfs_pkg::*;

    logic                          r_mode;
    logic signed [COORD_WIDTH-1:0] r_c_re, r_c_im;
    logic [ITER_WIDTH-1:0]         r_limit;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy, w_done;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= 1'b0;
            r_c_re  <= '0;
            r_c_im  <= '0;
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:  r_mode  <= i_cfg_data[0];
                REG_CRE:   r_c_re  <= i_cfg_data;
                REG_CIM:   r_c_im  <= i_cfg_data;
                REG_LIMIT: r_limit <= i_cfg_data[ITER_WIDTH-1:0];
                default:   r_mode  <= r_mode;
            endcase
        end
    end

    etfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_busy   (w_busy),
        .o_done   (w_done)
    );

    etfs_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .i_mode   (r_mode),
        .i_c_re   (r_c_re),
        .i_c_im   (r_c_im),
        .i_limit  (r_limit),
        .o_status (w_status),
        .o_result (o_result)
    );

    assign busy    = w_busy;
    assign o_valid = w_done;

endmodule

`default_nettype wire

FILE: tb/escape_time_fractal_smooth_tb.sv
//------------------------------------------------------------------------------
// escape_time_fractal_smooth_tb
// Self-checking bench for the escape-time fractal block. A directed table
// covers the extremes and corner cases. Random phases follow, each with its
// own mode, Julia constant and limit. Every result is compared with an
// in-bench model of the iteration, the log2 lookup and the normalization.
//------------------------------------------------------------------------------
module escape_time_fractal_smooth_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import etfs_pkg::*;

    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int     RAND_PHASES = 12;
    localparam int     PHASE_ITEMS = 155;
    localparam int     Q4_ONE      = 1 << FRAC_BITS;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    t_in_item                  i_item;
    logic                      o_valid;
    t_out_item                 o_result;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_WIDTH-1:0]  i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0] i_cfg_data;

    escape_time_fractal_smooth u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // Mirror of the block's registers.
    logic                    julia_mode;
    logic signed [63:0]      c_re;
    logic signed [63:0]      c_im;
    logic [ITER_WIDTH-1:0]   iter_limit;

    t_out_item   pending_points[$];
    int          mismatches;
    int          points_sent;
    int          points_checked;
    int          escaped_seen;
    longint      cycles;
    bit          idle_en;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_points.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Fixed-point product, floored, saturated to 64 bits signed.
    function automatic logic signed [63:0] qmul(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic signed [127:0] p;
        p = a * b;
        p = p >>> FRAC_BITS;
        if (p > 128'sh7fffffffffffffff) return 64'sh7fffffffffffffff;
        if (p < -128'sh8000000000000000) return 64'sh8000000000000000;
        return p[63:0];
    endfunction

    function automatic logic signed [63:0] qadd(logic signed [63:0] a,
                                                logic signed [63:0] b);
        logic signed [64:0] s;
        s = a + b;
        if (s > 65'sh0_7fffffffffffffff) return 64'sh7fffffffffffffff;
        if (s < -65'sh0_8000000000000000) return 64'sh8000000000000000;
        return s[63:0];
    endfunction

    // log2(1 + idx/2^LOG_TABLE_BITS) in Q16 by repeated squaring of a Q30 value.
    function automatic longint frac_log2(logic [LOG_TABLE_BITS-1:0] idx);
        logic [63:0] m;
        longint      bits;
        m = 64'h4000_0000 | (64'(idx) << (30 - LOG_TABLE_BITS));
        bits = 0;
        repeat (16) begin
            m = (m * m) >> 30;
            bits = bits * 2;
            if (m[31]) begin
                m = m >> 1;
                bits = bits + 1;
            end
        end
        return bits;
    endfunction

    function automatic longint log2_q16(logic [63:0] v, int fbits);
        int                        msb;
        logic [LOG_TABLE_BITS-1:0] idx;
        if (v == 0) return 0;
        msb = 63;
        while (!v[msb]) msb--;
        if (msb >= LOG_TABLE_BITS) idx = LOG_TABLE_BITS'(v >> (msb - LOG_TABLE_BITS));
        else idx = LOG_TABLE_BITS'(v << (LOG_TABLE_BITS - msb));
        return longint'(msb - fbits) * 65536 + frac_log2(idx);
    endfunction

    function automatic t_out_item escape_value(t_in_item pt);
        logic signed [63:0] zx, zy, cx, cy, xx, yy, xy, mag2;
        logic signed [63:0] four;
        longint             lim, iters, l1, l2, smooth, sv;
        t_out_item          r;
        four = 64'sd1 <<< (FRAC_BITS + 2);
        lim = (iter_limit == 0) ? 1 : longint'(iter_limit);
        if (julia_mode) begin
            zx = 64'(pt.point_x); zy = 64'(pt.point_y); cx = c_re; cy = c_im;
        end else begin
            zx = 0; zy = 0; cx = 64'(pt.point_x); cy = 64'(pt.point_y);
        end
        iters = 0;
        xx = qmul(zx, zx);
        yy = qmul(zy, zy);
        mag2 = qadd(xx, yy);
        while (mag2 < four && iters < lim) begin
            xy = qmul(zx, zy);
            zx = qadd(qadd(xx, -yy), cx);
            zy = qadd(qadd(xy, xy), cy);
            iters++;
            xx = qmul(zx, zx);
            yy = qmul(zy, zy);
            mag2 = qadd(xx, yy);
        end
        r.escaped = (mag2 >= four);
        r.iteration_count = ITER_WIDTH'(iters);
        if (r.escaped) begin
            l1 = log2_q16(mag2, FRAC_BITS);
            l2 = log2_q16(64'(l1 >>> 1), 16);
            smooth = iters * 65536 - l2;
            if (smooth < 0) smooth = 0;
            sv = smooth / lim;
            if (sv > 65536) sv = 65536;
            r.smooth_value = SV_WIDTH'(sv);
        end else begin
            r.smooth_value = Q16_ONE;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result sv=%0d it=%0d esc=%0b",
                             o_result.smooth_value, o_result.iteration_count,
                             o_result.escaped);
            end else begin
                want = pending_points.pop_front();
                points_checked++;
                if (o_result.escaped) escaped_seen++;
                if (o_result !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"Mismatch: expected sv=%0d it=%0d esc=%0b,",
                                  " got sv=%0d it=%0d esc=%0b"},
                                 want.smooth_value, want.iteration_count, want.escaped,
                                 o_result.smooth_value, o_result.iteration_count,
                                 o_result.escaped);
                end
            end
        end
    end

    task automatic wait_drained();
        start = 1'b0;
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] idx, logic [31:0] data);
        wait_drained();
        if (idle_en && $urandom_range(99) < 36) repeat ($urandom_range(1, 4)) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_MODE:  julia_mode = data[0];
            REG_CRE:   c_re = 64'(signed'(data));
            REG_CIM:   c_im = 64'(signed'(data));
            REG_LIMIT: iter_limit = data[ITER_WIDTH-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Presents one point; returns on the falling edge after the request is taken.
    task automatic send_point(t_in_item pt, output t_out_item predicted);
        if (idle_en && $urandom_range(99) < 36) begin
            start = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        start  = 1'b1;
        i_item = pt;
        do @(posedge i_clk); while (busy);
        predicted = escape_value(pt);
        pending_points.push_back(predicted);
        points_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int span);
        return 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic t_in_item rand_point();
        t_in_item pt;
        int       sel;
        sel = $urandom_range(9);
        if (sel < 2) begin
            pt.point_x = $urandom;
            pt.point_y = $urandom;
        end else if (sel < 8) begin
            pt.point_x = rand_coord(Q4_ONE / 4 * 9);
            pt.point_y = rand_coord(Q4_ONE * 3 / 2);
        end else begin
            pt.point_x = rand_coord(Q4_ONE / 2);
            pt.point_y = rand_coord(Q4_ONE / 2);
        end
        return pt;
    endfunction

    typedef struct {
        bit                       do_cfg;
        logic [CFG_IDX_WIDTH-1:0] idx;
        logic [31:0]              data;
        logic [31:0]              x;
        logic [31:0]              y;
        bit                       chk;
        t_out_item                want;
    } t_vector;

    localparam t_out_item NONE = '0;

    t_vector vectors[] = '{
        // Reset state: origin never escapes in Mandelbrot mode.
        '{0, REG_MODE, 0, 32'h0, 32'h0, 1, '{Q16_ONE, 16'd256, 1'b0}},
        '{0, REG_MODE, 0, 32'h7fffffff, 32'h7fffffff, 0, NONE},
        '{0, REG_MODE, 0, 32'h80000000, 32'h80000000, 0, NONE},
        '{0, REG_MODE, 0, 32'h80000000, 32'h7fffffff, 0, NONE},
        '{0, REG_MODE, 0, 32'hE0000000, 32'h0, 0, NONE},
        '{0, REG_MODE, 0, 32'h04000000, 32'h04000000, 0, NONE},
        // A zero limit behaves as a limit of one.
        '{1, REG_LIMIT, 0, 32'h0, 32'h0, 1, '{Q16_ONE, 16'd1, 1'b0}},
        '{1, REG_LIMIT, 32'hffff, 32'h7fffffff, 32'h0, 0, NONE},
        '{0, REG_MODE, 0, 32'h80000000, 32'h80000000, 0, NONE},
        '{1, REG_LIMIT, 1, 32'h10000000, 32'h0, 0, NONE},
        '{1, REG_LIMIT, 20, 32'hC0000000, 32'h01000000, 0, NONE},
        // Julia mode; a start point outside the circle escapes at once.
        '{1, REG_MODE, 32'hffff_ffff, 32'h30000000, 32'h0, 1, '{17'd0, 16'd0, 1'b1}},
        '{0, REG_MODE, 0, 32'h80000000, 32'h80000000, 1, '{17'd0, 16'd0, 1'b1}},
        '{0, REG_MODE, 0, 32'h0, 32'h0, 1, '{Q16_ONE, 16'd20, 1'b0}},
        '{1, REG_CRE, 32'h80000000, 32'h0, 32'h0, 0, NONE},
        '{1, REG_CIM, 32'h7fffffff, 32'h08000000, 32'hF8000000, 0, NONE},
        '{1, REG_CRE, 32'h7fffffff, 32'h0, 32'h0, 0, NONE},
        '{1, REG_CRE, 32'hF4000000, 32'h02000000, 32'h01000000, 0, NONE},
        '{1, REG_CIM, 32'h02c00000, 32'h0, 32'h10000000, 0, NONE},
        // Only the low mode bit counts: this returns to Mandelbrot.
        '{1, REG_MODE, 32'hffff_fffe, 32'hF0000000, 32'h0, 1, '{Q16_ONE, 16'd20, 1'b0}},
        '{0, REG_MODE, 0, 32'h7fffffff, 32'h80000000, 0, NONE}
    };

    initial begin
        t_out_item got;
        t_in_item  pt;
        int        lim;
        cycles = 0;
        mismatches = 0;
        points_sent = 0;
        points_checked = 0;
        escaped_seen = 0;
        idle_en = 1'b1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_item = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_data = '0;
        julia_mode = 1'b0;
        c_re = 0;
        c_im = 0;
        iter_limit = LIMIT_RESET;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (vectors[i]) begin
            if (vectors[i].do_cfg) cfg_write(vectors[i].idx, vectors[i].data);
            pt.point_x = vectors[i].x;
            pt.point_y = vectors[i].y;
            send_point(pt, got);
            if (vectors[i].chk && got !== vectors[i].want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"Directed row %0d: expected sv=%0d it=%0d esc=%0b,",
                              " model gives sv=%0d it=%0d esc=%0b"}, i,
                             vectors[i].want.smooth_value,
                             vectors[i].want.iteration_count, vectors[i].want.escaped,
                             got.smooth_value, got.iteration_count, got.escaped);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            idle_en = (ph != 4);
            cfg_write(REG_MODE, $urandom);
            if ($urandom_range(9) < 6) begin
                cfg_write(REG_CRE, rand_coord(Q4_ONE));
                cfg_write(REG_CIM, rand_coord(Q4_ONE));
            end else begin
                cfg_write(REG_CRE, $urandom);
                cfg_write(REG_CIM, $urandom);
            end
            if (ph == 7) lim = 256;
            else if (ph == 9) lim = $urandom_range(0, 1);
            else lim = $urandom_range(2, 48);
            cfg_write(REG_LIMIT, 32'(lim) | ($urandom & 32'hffff_0000));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                send_point(rand_point(), got);
            end
        end

        wait_drained();
        $display("Checked %0d of %0d points (%0d escaped) over %0d random phases",
                 points_checked, points_sent, escaped_seen, RAND_PHASES);
        $display("Mismatches: %0d, cycles: %0d", mismatches, cycles);
        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
